FILE: sv/lrcfr_pkg.sv
// Shared types, constants and colour helpers for the ring clock frame renderer.
// No dependencies; imported by led_ring_clock_frame_render.
`timescale 1ns / 1ps
`default_nettype none

package lrcfr_pkg;

    localparam int unsigned RING = 60;

    typedef logic [23:0] rgb_t;
    typedef logic [5:0]  pos_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_OFF_COLOR    = 3'd0,
        REG_MARKER_COLOR = 3'd1,
        REG_MINUTE_COLOR = 3'd2,
        REG_HOUR_COLOR   = 3'd3,
        REG_NOON_COLOR   = 3'd4,
        REG_ROTATION     = 3'd5,
        REG_FADE_INC     = 3'd6
    } reg_idx_t;

    localparam rgb_t       OFF_COLOR_RST    = 24'h020002;
    localparam rgb_t       MARKER_COLOR_RST = 24'h110011;
    localparam rgb_t       MINUTE_COLOR_RST = 24'h003599;
    localparam rgb_t       HOUR_COLOR_RST   = 24'h336600;
    localparam rgb_t       NOON_COLOR_RST   = 24'h460046;
    localparam pos_t       ROTATION_RST     = 6'd30;
    localparam logic [7:0] FADE_INC_RST     = 8'd3;

    localparam pos_t LAST_PIXEL = 6'(RING - 1);

    // value below 120 reduced into 0..59
    function automatic pos_t wrap60(input logic [6:0] v);
        return (v >= 7'(RING)) ? pos_t'(v - 7'(RING)) : pos_t'(v);
    endfunction

    // (a - b) mod 60 for a, b below 60
    function automatic pos_t sub60(input pos_t a, input pos_t b);
        return wrap60({1'b0, a} + 7'(RING) - {1'b0, b});
    endfunction

    // clock position on a multiple of five; c*13 >> 6 is c/5 below 60
    function automatic logic is_marker(input pos_t c);
        logic [9:0] t;
        logic [3:0] q;
        t = 10'(c) * 10'd13;
        q = t[9:6];
        return c == (6'({q, 2'b00}) + 6'(q));
    endfunction

    function automatic logic [3:0] mod12(input logic [4:0] h);
        if (h >= 5'd24) begin
            return 4'(h - 5'd24);
        end else if (h >= 5'd12) begin
            return 4'(h - 5'd12);
        end
        return 4'(h);
    endfunction

    function automatic logic [2:0] div12(input logic [5:0] m);
        return 3'(m >= 6'd12) + 3'(m >= 6'd24) + 3'(m >= 6'd36)
             + 3'(m >= 6'd48) + 3'(m >= 6'd60);
    endfunction

    function automatic rgb_t sat_add(input rgb_t a, input rgb_t b);
        rgb_t       r;
        logic [8:0] s;
        for (int ch = 0; ch < 3; ch++) begin
            s = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
            r[ch*8 +: 8] = s[8] ? 8'hFF : s[7:0];
        end
        return r;
    endfunction

    // drawing over the background, or with the background colour, replaces
    function automatic rgb_t draw(input rgb_t cur, input rgb_t c, input rgb_t off);
        return (c != off && cur != off) ? sat_add(cur, c) : c;
    endfunction

    function automatic rgb_t comet_rgb(input logic [13:0] prod);
        logic [7:0] b;
        b = (prod > 14'd255) ? 8'hFF : prod[7:0];
        return {b, 8'h00, 1'b0, b[7:1]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/led_ring_clock_frame_render.sv
// Ring clock frame renderer: request register, pixel sequencer and a
// five-stage colour pipeline ending in the output register.
// Depends on lrcfr_pkg.
//
// Usage: each item on the s_ channel is one frame request (time and comet
// step). The block answers with 60 items on the m_ channel, pixel 0 to 59,
// m_tlast on pixel 59. Colours and rotation come from the cfg_ write port,
// which must only be used between frames.
// Pixel 0 goes from the request register through the sequencer and stages 2
// to 6 to the m_ channel. The pixel sequencer issues one pixel per cycle while
// m_tready does not stall the pipeline; the next request is held in the request
// register and starts right after pixel 59 is issued.
// The colour pipeline (distances and comet level, base colour, minute,
// hour, comet) advances as a whole; when m_tready is low while a pixel is
// presented, every stage and the sequencer hold, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// default register values.
`timescale 1ns / 1ps
`default_nettype none

module led_ring_clock_frame_render
    import lrcfr_pkg::*;
#(
    parameter int TRAIL_STEPS  = 18,
    parameter int MINUTE_WIDTH = 2,
    parameter int HOUR_WIDTH   = 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // hours [4:0], minutes [10:5], seconds [16:11], anim_step [21:17]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_index [5:0], pixel_color [29:6]
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    // configuration registers
    rgb_t       off_color_reg, marker_color_reg, minute_color_reg;
    rgb_t       hour_color_reg, noon_color_reg;
    pos_t       rotation_reg;
    logic [7:0] fade_inc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_color_reg    <= OFF_COLOR_RST;
            marker_color_reg <= MARKER_COLOR_RST;
            minute_color_reg <= MINUTE_COLOR_RST;
            hour_color_reg   <= HOUR_COLOR_RST;
            noon_color_reg   <= NOON_COLOR_RST;
            rotation_reg     <= ROTATION_RST;
            fade_inc_reg     <= FADE_INC_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_OFF_COLOR:    off_color_reg    <= cfg_wr_data;
                REG_MARKER_COLOR: marker_color_reg <= cfg_wr_data;
                REG_MINUTE_COLOR: minute_color_reg <= cfg_wr_data;
                REG_HOUR_COLOR:   hour_color_reg   <= cfg_wr_data;
                REG_NOON_COLOR:   noon_color_reg   <= cfg_wr_data;
                REG_ROTATION:     rotation_reg     <= cfg_wr_data[5:0];
                REG_FADE_INC:     fade_inc_reg     <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    logic adv;          // whole pipeline moves
    logic a_take;       // sequencer takes the request from the request register
    logic s_accept;

    // ---------------- request register ----------------
    logic [4:0] in_hours, in_step;
    logic [5:0] in_minutes, in_seconds;
    assign in_hours   = s_tdata[4:0];
    assign in_minutes = s_tdata[10:5];
    assign in_seconds = s_tdata[16:11];
    assign in_step    = s_tdata[21:17];

    pos_t rot_next, pos_m_next, pos_h_next, spos_next, back_n_next;
    logic [5:0] hour_base;
    logic comet_en_next, tail_en_next;

    always_comb begin
        rot_next      = wrap60({1'b0, rotation_reg});
        pos_m_next    = wrap60({1'b0, wrap60({1'b0, in_minutes})} + {1'b0, rot_next});
        hour_base     = 6'({mod12(in_hours), 2'b00}) + 6'(mod12(in_hours));
        pos_h_next    = wrap60(7'(hour_base) + 7'(rot_next) + 7'(div12(in_minutes)));
        spos_next     = wrap60({1'b0, wrap60({1'b0, in_seconds})} + {1'b0, rot_next});
        comet_en_next = {1'b0, in_step} < 6'(TRAIL_STEPS);
        back_n_next   = 6'(TRAIL_STEPS) - {1'b0, in_step};
        tail_en_next  = (in_step != 5'd0) && ({1'b0, in_step} != 6'(TRAIL_STEPS - 1));
    end

    logic       a_valid_reg;
    pos_t       a_rot_reg, a_pos_m_reg, a_pos_h_reg, a_spos_reg, a_back_n_reg;
    logic [4:0] a_step_reg;
    logic       a_comet_en_reg, a_tail_en_reg;

    assign s_tready = !a_valid_reg || a_take;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_take) begin
            a_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            a_rot_reg      <= rot_next;
            a_pos_m_reg    <= pos_m_next;
            a_pos_h_reg    <= pos_h_next;
            a_spos_reg     <= spos_next;
            a_back_n_reg   <= back_n_next;
            a_step_reg     <= in_step;
            a_comet_en_reg <= comet_en_next;
            a_tail_en_reg  <= tail_en_next;
        end
    end

    // ---------------- pixel sequencer ----------------
    logic       busy_reg;
    pos_t       p_reg, g_rot_reg, g_pos_m_reg, g_pos_h_reg, g_head_reg;
    logic [4:0] g_step_reg;
    logic       g_comet_en_reg, g_tail_en_reg;
    logic       frame_end;

    assign frame_end = !busy_reg || p_reg == LAST_PIXEL;
    assign a_take    = adv && a_valid_reg && frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (adv && frame_end) begin
            busy_reg <= a_valid_reg;
        end
        if (a_take) begin
            p_reg          <= '0;
            g_rot_reg      <= a_rot_reg;
            g_pos_m_reg    <= a_pos_m_reg;
            g_pos_h_reg    <= a_pos_h_reg;
            g_head_reg     <= sub60(a_spos_reg, a_back_n_reg);
            g_step_reg     <= a_step_reg;
            g_comet_en_reg <= a_comet_en_reg;
            g_tail_en_reg  <= a_tail_en_reg;
        end else if (adv && busy_reg && !frame_end) begin
            p_reg <= p_reg + 6'd1;
        end
    end

    // ---------------- stage 2: distances, comet level ----------------
    pos_t        p_inc;
    logic        is_head, is_tail;
    logic [5:0]  level;

    always_comb begin
        p_inc   = (p_reg == LAST_PIXEL) ? '0 : p_reg + 6'd1;
        is_head = g_comet_en_reg && p_reg == g_head_reg;
        is_tail = g_comet_en_reg && g_tail_en_reg && p_inc == g_head_reg;
        level   = is_head ? {1'b0, g_step_reg} + 6'd1 : {1'b0, g_step_reg};
    end

    logic        s2_valid_reg;
    pos_t        s2_idx_reg, s2_clk_reg;
    logic        s2_noon_reg, s2_m_hit_reg, s2_h_hit_reg, s2_c_hit_reg;
    logic [13:0] s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= busy_reg;
        end
        if (adv) begin
            s2_idx_reg   <= p_reg;
            s2_clk_reg   <= sub60(p_reg, g_rot_reg);
            s2_noon_reg  <= p_reg == g_rot_reg;
            s2_m_hit_reg <= sub60(g_pos_m_reg, p_reg) < 6'(MINUTE_WIDTH);
            s2_h_hit_reg <= sub60(g_pos_h_reg, p_reg) < 6'(HOUR_WIDTH);
            s2_c_hit_reg <= is_head || is_tail;
            s2_prod_reg  <= 14'(fade_inc_reg) * 14'(level);
        end
    end

    // ---------------- stage 3: base frame colour, comet colour ----------------
    logic s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;
    pos_t s3_idx_reg, s4_idx_reg, s5_idx_reg, s6_idx_reg;
    logic s3_m_hit_reg, s3_h_hit_reg, s4_h_hit_reg;
    logic s3_c_hit_reg, s4_c_hit_reg, s5_c_hit_reg;
    rgb_t s3_base_reg, s4_col_reg, s5_col_reg, s6_col_reg;
    rgb_t s3_comet_reg, s4_comet_reg, s5_comet_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
        if (adv) begin
            // stage 3
            s3_idx_reg   <= s2_idx_reg;
            s3_base_reg  <= s2_noon_reg ? noon_color_reg :
                            (is_marker(s2_clk_reg) ? marker_color_reg : off_color_reg);
            s3_comet_reg <= comet_rgb(s2_prod_reg);
            s3_m_hit_reg <= s2_m_hit_reg;
            s3_h_hit_reg <= s2_h_hit_reg;
            s3_c_hit_reg <= s2_c_hit_reg;
            // stage 4: minute hand
            s4_idx_reg   <= s3_idx_reg;
            s4_col_reg   <= s3_m_hit_reg ?
                            draw(s3_base_reg, minute_color_reg, off_color_reg) : s3_base_reg;
            s4_comet_reg <= s3_comet_reg;
            s4_h_hit_reg <= s3_h_hit_reg;
            s4_c_hit_reg <= s3_c_hit_reg;
            // stage 5: hour hand
            s5_idx_reg   <= s4_idx_reg;
            s5_col_reg   <= s4_h_hit_reg ?
                            draw(s4_col_reg, hour_color_reg, off_color_reg) : s4_col_reg;
            s5_comet_reg <= s4_comet_reg;
            s5_c_hit_reg <= s4_c_hit_reg;
            // stage 6: comet, output register
            s6_idx_reg   <= s5_idx_reg;
            s6_col_reg   <= s5_c_hit_reg ?
                            draw(s5_col_reg, s5_comet_reg, off_color_reg) : s5_col_reg;
        end
    end

    assign adv      = !s6_valid_reg || m_tready;
    assign m_tvalid = s6_valid_reg;
    assign m_tdata  = {2'b00, s6_col_reg, s6_idx_reg};
    assign m_tlast  = s6_idx_reg == LAST_PIXEL;

    // ---------------- checks ----------------
    a_pixel_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (!m_tvalid || m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))
        else $error("pixel index out of order");

    a_seq_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !adv) |=> (busy_reg && p_reg == $past(p_reg)))
        else $error("sequencer moved during stall");

    a_take_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_take && !s_accept) |=> (!a_valid_reg && busy_reg && p_reg == '0))
        else $error("request not handed to sequencer");

endmodule

`default_nettype wire
